// ===== hw/rtl/block_ack_tracker_top_assert.svh =====
// assertion macros shared by the tracker modules
`ifndef BLOCK_ACK_TRACKER_TOP_ASSERT_SVH
`define BLOCK_ACK_TRACKER_TOP_ASSERT_SVH

// same-cycle implication, checked outside reset
`define BAT_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("block ack tracker check failed");

// next-cycle implication, checked outside reset
`define BAT_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("block ack tracker check failed");

`endif

// ===== hw/rtl/bat_pkg.sv =====
`default_nettype none

package bat_pkg;

   localparam int SEGMENTS_PER_BLOCK = 8;
   localparam int SEGMENT_BYTES      = 1024;
   localparam int MAP_BITS           = 8;
   localparam int SEG_LIMIT_INT      = (SEGMENTS_PER_BLOCK > MAP_BITS) ? MAP_BITS :
                                       (SEGMENTS_PER_BLOCK < 1) ? 1 : SEGMENTS_PER_BLOCK;

   localparam logic [3:0]  SEG_LIMIT         = 4'(SEG_LIMIT_INT);
   localparam logic [10:0] SEG_BYTES_LEN     = 11'(SEGMENT_BYTES);
   localparam logic [3:0]  MAX_RETRIES_RESET = 4'd3;

   // input modes
   localparam logic [1:0] MODE_START   = 2'd0;
   localparam logic [1:0] MODE_ACK     = 2'd1;
   localparam logic [1:0] MODE_TIMEOUT = 2'd2;

   // result kinds
   localparam logic KIND_STATUS = 1'b0;
   localparam logic KIND_RESEND = 1'b1;

   // status codes
   localparam logic [2:0] STATUS_WAITING     = 3'd0;
   localparam logic [2:0] STATUS_COMPLETE    = 3'd1;
   localparam logic [2:0] STATUS_WRONG_BLOCK = 3'd2;
   localparam logic [2:0] STATUS_DUPLICATE   = 3'd3;
   localparam logic [2:0] STATUS_EXHAUSTED   = 3'd4;
   localparam logic [2:0] STATUS_BAD_SEGMENT = 3'd5;

   typedef struct packed {
      logic [1:0]  mode;
      logic [15:0] block_id;
      logic [15:0] ack_segment;
      logic [3:0]  segment_count;
      logic [10:0] final_length;
   } req_type;

   typedef struct packed {
      logic        kind;
      logic [2:0]  status;
      logic [3:0]  resend_segment;
      logic [10:0] resend_length;
      logic        last;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic exec;
      logic step;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic go_scan;
      logic scan_last;
   } stat_type;

endpackage

`default_nettype wire

// ===== hw/rtl/bat_ctrl.sv =====
`default_nettype none
`include "block_ack_tracker_top_assert.svh"

module bat_ctrl (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 start,
   input  bat_pkg::stat_type   stat,
   output bat_pkg::cmd_type    cmd,
   output logic                busy
);

   typedef enum logic [1:0] {ST_IDLE, ST_EXEC, ST_SCAN} state_type;

   state_type state_ff, state_in;
   logic      busy_ff;

   // commands decoded from the state
   always_comb begin
      cmd.load = (state_ff == ST_IDLE) && start;
      cmd.exec = (state_ff == ST_EXEC);
      cmd.step = (state_ff == ST_SCAN);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            state_in = stat.go_scan ? ST_SCAN : ST_IDLE;
         end
         ST_SCAN: begin
            if (stat.scan_last) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state and registered busy
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         busy_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         busy_ff  <= (state_in != ST_IDLE);
      end
   end

   assign busy = busy_ff;

   `BAT_ASSERT_NOW(a_busy_matches_state, 1'b1, busy_ff == (state_ff != ST_IDLE))
   `BAT_ASSERT_NEXT(a_accept_enters_exec, start && !busy_ff, state_ff == ST_EXEC)

endmodule

`default_nettype wire

// ===== hw/rtl/bat_dp.sv =====
`default_nettype none
`include "block_ack_tracker_top_assert.svh"

module bat_dp (
   input  wire                 clock,
   input  wire                 reset,
   input  bat_pkg::cmd_type    cmd,
   input  bat_pkg::req_type    req_data,
   input  wire                 cfg_we,
   input  wire  [3:0]          cfg_data,
   output bat_pkg::stat_type   stat,
   output logic                rsp_strobe,
   output bat_pkg::rsp_type    rsp_data
);

   bat_pkg::req_type req_ff;
   logic [3:0]       max_retries_ff;
   logic [7:0]       ack_map_ff, ack_map_in;
   logic [3:0]       acked_total_ff, acked_total_in;
   logic [3:0]       retry_count_ff, retry_count_in;
   logic [15:0]      current_block_ff, current_block_in;
   logic [3:0]       count_ff, count_in;
   logic [10:0]      tail_ff, tail_in;
   logic             active_ff, active_in;
   logic [7:0]       pending_ff, pending_in;
   logic             rsp_strobe_ff;
   bat_pkg::rsp_type rsp_data_ff;

   logic [7:0]       seg_mask;
   logic [7:0]       fresh_pending;
   logic [2:0]       ack_idx;
   logic [3:0]       sat_count;
   logic [10:0]      sat_len;
   logic [2:0]       exec_status;
   logic             go_scan;
   logic [7:0]       pick;
   logic [2:0]       pick_idx;
   logic             found;
   logic [7:0]       rest;
   logic [3:0]       pick_seg;

   // valid segments of the current block
   always_comb begin
      for (int i = 0; i < 8; i++) begin
         seg_mask[i] = (4'(i) < count_ff);
      end
   end

   assign fresh_pending = ~ack_map_ff & seg_mask;
   assign ack_idx       = req_ff.ack_segment[2:0] - 3'd1;

   // start saturation
   always_comb begin
      sat_count = req_ff.segment_count;
      if (sat_count < 4'd1) sat_count = 4'd1;
      if (sat_count > bat_pkg::SEG_LIMIT) sat_count = bat_pkg::SEG_LIMIT;
      sat_len = req_ff.final_length;
      if (sat_len > bat_pkg::SEG_BYTES_LEN) sat_len = bat_pkg::SEG_BYTES_LEN;
   end

   // decision for one item
   always_comb begin
      ack_map_in       = ack_map_ff;
      acked_total_in   = acked_total_ff;
      retry_count_in   = retry_count_ff;
      current_block_in = current_block_ff;
      count_in         = count_ff;
      tail_in          = tail_ff;
      active_in        = active_ff;
      pending_in       = pending_ff;
      exec_status      = bat_pkg::STATUS_WAITING;
      go_scan          = 1'b0;
      if (req_ff.mode == bat_pkg::MODE_START) begin
         current_block_in = req_ff.block_id;
         count_in         = sat_count;
         tail_in          = sat_len;
         ack_map_in       = '0;
         acked_total_in   = '0;
         retry_count_in   = '0;
         active_in        = 1'b1;
      end else if (req_ff.mode == bat_pkg::MODE_ACK) begin
         priority if (!active_ff || req_ff.block_id != current_block_ff) begin
            active_in   = 1'b0;
            exec_status = bat_pkg::STATUS_WRONG_BLOCK;
         end else if (req_ff.ack_segment == 16'd0 ||
                      req_ff.ack_segment > {12'd0, count_ff}) begin
            active_in   = 1'b0;
            exec_status = bat_pkg::STATUS_BAD_SEGMENT;
         end else if (ack_map_ff[ack_idx]) begin
            active_in   = 1'b0;
            exec_status = bat_pkg::STATUS_DUPLICATE;
         end else begin
            ack_map_in          = ack_map_ff;
            ack_map_in[ack_idx] = 1'b1;
            acked_total_in      = acked_total_ff + 4'd1;
            if (acked_total_in >= count_ff) begin
               active_in   = 1'b0;
               exec_status = bat_pkg::STATUS_COMPLETE;
            end
         end
      end else if (req_ff.mode == bat_pkg::MODE_TIMEOUT && active_ff) begin
         if (retry_count_ff >= max_retries_ff) begin
            active_in   = 1'b0;
            exec_status = bat_pkg::STATUS_EXHAUSTED;
         end else begin
            retry_count_in = retry_count_ff + 4'd1;
            pending_in     = fresh_pending;
            go_scan        = (fresh_pending != 8'd0);
         end
      end
      if (!cmd.exec) begin
         ack_map_in       = ack_map_ff;
         acked_total_in   = acked_total_ff;
         retry_count_in   = retry_count_ff;
         current_block_in = current_block_ff;
         count_in         = count_ff;
         tail_in          = tail_ff;
         active_in        = active_ff;
         pending_in       = pending_ff;
      end
      if (cmd.step) pending_in = rest;
   end

   // lowest pending segment
   always_comb begin
      pick     = '0;
      pick_idx = '0;
      found    = 1'b0;
      for (int i = 0; i < 8; i++) begin
         if (pending_ff[i] && !found) begin
            pick[i]  = 1'b1;
            pick_idx = 3'(i);
            found    = 1'b1;
         end
      end
   end

   assign rest     = pending_ff & ~pick;
   assign pick_seg = {1'b0, pick_idx} + 4'd1;

   assign stat.go_scan   = go_scan;
   assign stat.scan_last = (rest == 8'd0);

   // item latch and pending mask
   always_ff @(posedge clock) begin
      if (cmd.load) req_ff <= req_data;
      pending_ff <= pending_in;
   end

   // tracker state and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         max_retries_ff   <= bat_pkg::MAX_RETRIES_RESET;
         ack_map_ff       <= '0;
         acked_total_ff   <= '0;
         retry_count_ff   <= '0;
         current_block_ff <= '0;
         count_ff         <= '0;
         tail_ff          <= '0;
         active_ff        <= 1'b0;
      end else begin
         if (cfg_we) max_retries_ff <= cfg_data;
         ack_map_ff       <= ack_map_in;
         acked_total_ff   <= acked_total_in;
         retry_count_ff   <= retry_count_in;
         current_block_ff <= current_block_in;
         count_ff         <= count_in;
         tail_ff          <= tail_in;
         active_ff        <= active_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) rsp_strobe_ff <= 1'b0;
      else       rsp_strobe_ff <= cmd.step || (cmd.exec && !go_scan);
   end

   always_ff @(posedge clock) begin
      if (cmd.step) begin
         rsp_data_ff.kind           <= bat_pkg::KIND_RESEND;
         rsp_data_ff.status         <= bat_pkg::STATUS_WAITING;
         rsp_data_ff.resend_segment <= pick_seg;
         rsp_data_ff.resend_length  <= (pick_seg == count_ff) ? tail_ff
                                                              : bat_pkg::SEG_BYTES_LEN;
         rsp_data_ff.last           <= (rest == 8'd0);
      end else if (cmd.exec) begin
         rsp_data_ff.kind           <= bat_pkg::KIND_STATUS;
         rsp_data_ff.status         <= exec_status;
         rsp_data_ff.resend_segment <= '0;
         rsp_data_ff.resend_length  <= '0;
         rsp_data_ff.last           <= 1'b1;
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

   `BAT_ASSERT_NOW(a_scan_has_work, cmd.step, pending_ff != 8'd0)
   `BAT_ASSERT_NEXT(a_status_is_last, cmd.exec && !go_scan, rsp_strobe_ff && rsp_data_ff.last)
   `BAT_ASSERT_NEXT(a_scan_end_marked, cmd.step && (rest == 8'd0),
                    rsp_strobe_ff && rsp_data_ff.last && rsp_data_ff.kind)

endmodule

`default_nettype wire

// ===== hw/rtl/block_ack_tracker_top.sv =====
// a status result is strobed in the cycle after the exec cycle; an accepted start moves the tracker into its exec state
// a new start is taken only while idle; a timeout emits one resend per pending segment (up to 8) before it is done
// the scan over the pending mask emits one resend per cycle from the datapath
// results are strobed for one cycle only; the receiver cannot stall
// reset: synchronous, active high; tracker idle, max_retries back to 3
`default_nettype none

module block_ack_tracker_top (
   input  wire                clock,
   input  wire                reset,
   input  wire                start,
   output logic               busy,
   input  bat_pkg::req_type   req_data,
   output logic               rsp_strobe,
   output bat_pkg::rsp_type   rsp_data,
   input  wire                csr_valid,
   output logic               csr_ready,
   input  wire  [3:0]         csr_data
);

   bat_pkg::cmd_type  cmd;
   bat_pkg::stat_type stat;

   // configuration is taken while no item is in flight
   assign csr_ready = ~busy;

   bat_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .stat  (stat),
      .cmd   (cmd),
      .busy  (busy)
   );

   bat_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .req_data   (req_data),
      .cfg_we     (csr_valid & csr_ready),
      .cfg_data   (csr_data),
      .stat       (stat),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

endmodule

`default_nettype wire
